>>> hw/rtl/tcft_pkg.sv
// Shared types and constants for the tempo clock follower transport.
package tcft_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int INC_W        = 22;
  localparam int TICK_W       = INC_W + 1 - PHASE_BITS;
  localparam int BPM_W        = 10;
  localparam int KNOB_W       = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;
  localparam int SEC_PER_MIN  = 60;
  localparam int EDGE_SAT_MUL = 8;

  localparam logic [INC_W-1:0] INC_MAX = {INC_W{1'b1}};

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_KNOB = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BPM_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_DIV,
    S_TICK,
    S_OUT
  } state_t;

endpackage

>>> hw/rtl/tempo_clock_follower_transport.sv
// Tempo clock follower transport: phase accumulator, clock sync and knob tempo.
//
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+---------------------------
//  in_      | valid, ready, command, knob_position    | one command item
//  out_     | valid, ready, advanced .. tick_increment| one status item per input
//  cfg_     | valid, ready, index, data               | register write, always ready
//
// Control step: the playhead moves one tick at a time in S_TICK, up to 64 whole ticks.
// Knob or edge recompute: a bit-serial restoring divider, one quotient bit a cycle,
// after S_MUL and S_SCALE for a knob, and followed by S_OUT and the output register.
// Synchronous active-low reset; no clearing pass. in_ready is high only when idle;
// a stalled out_ready holds the finished item in the output register.
module tempo_clock_follower_transport
  import tcft_pkg::*;
#(
  parameter int TICKS_PER_BEAT = 48,
  parameter int LOOP_TICKS     = 768,
  parameter int CONTROL_RATE   = 3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [KNOB_W-1:0]     in_knob_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_advanced,
  output logic [9:0]            out_play_position,
  output logic                  out_beat_crossed,
  output logic                  out_loop_wrapped,
  output logic                  out_clock_following,
  output logic [INC_W-1:0]      out_tick_increment,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PH_W     = $clog2(LOOP_TICKS);
  localparam int OFF_W    = $clog2(TICKS_PER_BEAT);
  localparam int TPB_W    = $clog2(TICKS_PER_BEAT + 1);
  localparam int EDGE_SAT = CONTROL_RATE * EDGE_SAT_MUL;
  localparam int SSE_W    = $clog2(EDGE_SAT + 1);
  localparam int DEN_KNOB = SEC_PER_MIN * CONTROL_RATE;
  localparam int DEN_W    = ($clog2(DEN_KNOB + 1) > 15) ? $clog2(DEN_KNOB + 1) : 15;
  localparam int BT_W     = BPM_W + TPB_W;
  localparam int NUM_W    = BT_W + PHASE_BITS;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int HALF_BEAT = TICKS_PER_BEAT / 2;

  // configuration
  logic [8:0]  bpm_min_r, bpm_max_r;
  logic [11:0] knob_thr_r;
  logic [14:0] max_gap_r, hold_steps_r;

  // transport state
  state_t                  state_r, state_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [INC_W-1:0]        inc_r, inc_nxt;
  logic [PH_W-1:0]         ph_r, ph_nxt;
  logic [OFF_W-1:0]        off_r, off_nxt;
  logic [SSE_W-1:0]        steps_r, steps_nxt;
  logic [14:0]             hold_r, hold_nxt;
  logic [KNOB_W-1:0]       last_knob_r, last_knob_nxt;
  logic                    known_r, known_nxt;
  logic [TICK_W-1:0]       ticks_r, ticks_nxt;
  logic                    adv_r, adv_nxt, beat_r, beat_nxt, wrap_r, wrap_nxt;

  // datapath
  logic [KNOB_W-1:0]       knob_r, knob_nxt;
  logic signed [22:0]      prod_r, prod_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_adv_r, out_adv_nxt, out_beat_r, out_beat_nxt;
  logic                    out_wrap_r, out_wrap_nxt, out_follow_r, out_follow_nxt;
  logic [9:0]              out_pos_r, out_pos_nxt;
  logic [INC_W-1:0]        out_inc_r, out_inc_nxt;

  // combinational helpers
  logic [INC_W:0]          total;
  logic [PH_W-1:0]         ph_up;
  logic [OFF_W-1:0]        off_up;
  logic [KNOB_W-1:0]       knob_dist;
  logic signed [22:0]      knob_s, diff_s;
  logic signed [11:0]      scaled_s, bpm_s;
  logic [BPM_W-1:0]        bpm_u;
  logic [BT_W-1:0]         bpm_ticks;
  logic [DEN_W:0]          rem_sh;
  logic                    q_bit, gap_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  assign out_valid           = out_valid_r;
  assign out_advanced        = out_adv_r;
  assign out_play_position   = out_pos_r;
  assign out_beat_crossed    = out_beat_r;
  assign out_loop_wrapped    = out_wrap_r;
  assign out_clock_following = out_follow_r;
  assign out_tick_increment  = out_inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_min_r    <= 9'd40;
      bpm_max_r    <= 9'd240;
      knob_thr_r   <= 12'd32;
      max_gap_r    <= 15'd6000;
      hold_steps_r <= 15'd6000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BPM_MIN:   bpm_min_r    <= cfg_data[8:0];
        REG_BPM_MAX:   bpm_max_r    <= cfg_data[8:0];
        REG_KNOB_THR:  knob_thr_r   <= cfg_data[11:0];
        REG_MAX_GAP:   max_gap_r    <= cfg_data;
        REG_HOLD_STEP: hold_steps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    total     = {1'b0, inc_r} + (INC_W + 1)'(phase_r);
    ph_up     = (ph_r == PH_W'(LOOP_TICKS - 1)) ? '0 : ph_r + 1'b1;
    off_up    = ((ph_r == PH_W'(LOOP_TICKS - 1)) || (off_r == OFF_W'(TICKS_PER_BEAT - 1)))
                ? '0 : off_r + 1'b1;
    knob_dist = (in_knob_position > last_knob_r) ? in_knob_position - last_knob_r
                                                 : last_knob_r - in_knob_position;
    knob_s    = 23'(signed'({1'b0, knob_r}));
    diff_s    = 23'(signed'({1'b0, bpm_max_r}) - signed'({1'b0, bpm_min_r}));
    scaled_s  = signed'({prod_r[22], prod_r[22:12]});
    bpm_s     = scaled_s + signed'({3'b000, bpm_min_r});
    bpm_u     = bpm_s[11] ? '0 : bpm_s[BPM_W-1:0];
    bpm_ticks = BT_W'(bpm_u) * BT_W'(TICKS_PER_BEAT);
    rem_sh    = {rem_r, num_r[NUM_W-1]};
    q_bit     = (rem_sh >= {1'b0, den_r});
    gap_ok    = (steps_r != '0) && ({{15{1'b0}}, steps_r}
                 <= {{SSE_W{1'b0}}, max_gap_r});

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    inc_nxt       = inc_r;
    ph_nxt        = ph_r;
    off_nxt       = off_r;
    steps_nxt     = steps_r;
    hold_nxt      = hold_r;
    last_knob_nxt = last_knob_r;
    known_nxt     = known_r;
    ticks_nxt     = ticks_r;
    adv_nxt       = adv_r;
    beat_nxt      = beat_r;
    wrap_nxt      = wrap_r;
    knob_nxt      = knob_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_adv_nxt    = out_adv_r;
    out_beat_nxt   = out_beat_r;
    out_wrap_nxt   = out_wrap_r;
    out_follow_nxt = out_follow_r;
    out_pos_nxt    = out_pos_r;
    out_inc_nxt    = out_inc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          adv_nxt   = 1'b0;
          beat_nxt  = 1'b0;
          wrap_nxt  = 1'b0;
          state_nxt = S_OUT;
          unique case (in_command)
            CMD_STEP: begin
              if (steps_r < SSE_W'(EDGE_SAT)) steps_nxt = steps_r + 1'b1;
              if (hold_r != '0) hold_nxt = hold_r - 1'b1;
              if (inc_r != '0) begin
                phase_nxt = total[PHASE_BITS-1:0];
                ticks_nxt = total[INC_W:PHASE_BITS];
                if (total[INC_W:PHASE_BITS] != '0) begin
                  adv_nxt   = 1'b1;
                  state_nxt = S_TICK;
                end
              end
            end
            CMD_EDGE: begin
              if (gap_ok) begin
                num_nxt   = NUM_W'(TICKS_PER_BEAT) << PHASE_BITS;
                den_nxt   = DEN_W'(steps_r);
                rem_nxt   = '0;
                cnt_nxt   = CNT_W'(NUM_W);
                state_nxt = S_DIV;
                if (off_r != '0) begin
                  if (off_r > OFF_W'(HALF_BEAT)) begin
                    ph_nxt  = ph_up;
                    off_nxt = off_up;
                  end else begin
                    ph_nxt  = ph_r - 1'b1;
                    off_nxt = off_r - 1'b1;
                  end
                end
              end
              steps_nxt = '0;
              hold_nxt  = hold_steps_r;
            end
            CMD_KNOB: begin
              if (hold_r != '0) begin
                known_nxt = 1'b0;
              end else if (!known_r || (knob_dist >= knob_thr_r)) begin
                last_knob_nxt = in_knob_position;
                known_nxt     = 1'b1;
                knob_nxt      = in_knob_position;
                state_nxt     = S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = knob_s * diff_s;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        num_nxt   = {bpm_ticks, {PHASE_BITS{1'b0}}};
        den_nxt   = DEN_W'(DEN_KNOB);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(NUM_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          inc_nxt   = (num_r[NUM_W-1:INC_W] != '0) ? INC_MAX : num_r[INC_W-1:0];
          state_nxt = S_OUT;
        end else begin
          rem_nxt = q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
          num_nxt = {num_r[NUM_W-2:0], q_bit};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_TICK: begin
        ph_nxt    = ph_up;
        off_nxt   = off_up;
        if (off_up == '0) beat_nxt = 1'b1;
        if (ph_up == '0) wrap_nxt = 1'b1;
        ticks_nxt = ticks_r - 1'b1;
        if (ticks_r == TICK_W'(1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_adv_nxt    = adv_r;
          out_beat_nxt   = beat_r;
          out_wrap_nxt   = wrap_r;
          out_follow_nxt = (hold_r != '0);
          out_pos_nxt    = 10'(ph_r);
          out_inc_nxt    = inc_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      inc_r       <= '0;
      ph_r        <= '0;
      off_r       <= '0;
      steps_r     <= '0;
      hold_r      <= '0;
      last_knob_r <= '0;
      known_r     <= 1'b0;
      ticks_r     <= '0;
      adv_r       <= 1'b0;
      beat_r      <= 1'b0;
      wrap_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      inc_r       <= inc_nxt;
      ph_r        <= ph_nxt;
      off_r       <= off_nxt;
      steps_r     <= steps_nxt;
      hold_r      <= hold_nxt;
      last_knob_r <= last_knob_nxt;
      known_r     <= known_nxt;
      ticks_r     <= ticks_nxt;
      adv_r       <= adv_nxt;
      beat_r      <= beat_nxt;
      wrap_r      <= wrap_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    knob_r       <= knob_nxt;
    prod_r       <= prod_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    out_adv_r    <= out_adv_nxt;
    out_beat_r   <= out_beat_nxt;
    out_wrap_r   <= out_wrap_nxt;
    out_follow_r <= out_follow_nxt;
    out_pos_r    <= out_pos_nxt;
    out_inc_r    <= out_inc_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ph_r} < (PH_W + 1)'(LOOP_TICKS))
    else $error("playhead beyond loop length");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, off_r} < (OFF_W + 1)'(TICKS_PER_BEAT))
    else $error("beat offset out of range");

  a_tick_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (ticks_r != '0))
    else $error("tick loop entered with no ticks left");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not leave idle");

  a_edge_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_EDGE))
    |=> ((hold_r == $past(hold_steps_r)) && (steps_r == '0)))
    else $error("edge did not restart stopwatch and hold");
`endif

endmodule

>>> bench/tcft_monitor.sv
// Channel monitor for the tempo transport: predicts each status item and compares.
`timescale 1ns / 100ps

module tcft_monitor
  import tcft_pkg::*;
#(
  parameter int TICKS_PER_BEAT = 48,
  parameter int LOOP_TICKS     = 768,
  parameter int CONTROL_RATE   = 3000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [KNOB_W-1:0]     in_knob_position,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_advanced,
  input  logic [9:0]            out_play_position,
  input  logic                  out_beat_crossed,
  input  logic                  out_loop_wrapped,
  input  logic                  out_clock_following,
  input  logic [INC_W-1:0]      out_tick_increment,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam longint PHASE_ONE = longint'(1) << PHASE_BITS;
  localparam longint RATE_DIV  = longint'(SEC_PER_MIN) * CONTROL_RATE;
  localparam int     WATCH_MAX = CONTROL_RATE * EDGE_SAT_MUL;

  typedef struct packed {
    logic             advanced;
    logic [9:0]       play_position;
    logic             beat_crossed;
    logic             loop_wrapped;
    logic             clock_following;
    logic [INC_W-1:0] tick_increment;
  } status_t;

  int bpm_lo, bpm_hi, move_thr, gap_limit, hold_len;
  int phase_acc, rate, playhead, stopwatch, hold_cnt, knob_last;
  bit knob_known;

  status_t status_due[$];
  int      n_in, n_out, mis_count;

  assign outstanding = n_in - n_out;

  function automatic int clamp_rate(longint v);
    return (v > longint'(INC_MAX)) ? int'(INC_MAX) : int'(v);
  endfunction

  function automatic string show(status_t s);
    return $sformatf("adv=%0d pos=%0d beat=%0d wrap=%0d follow=%0d inc=%0d",
                     s.advanced, s.play_position, s.beat_crossed, s.loop_wrapped,
                     s.clock_following, s.tick_increment);
  endfunction

  task automatic apply_command(input logic [1:0] cmd, input logic [KNOB_W-1:0] knob,
                               output status_t st);
    longint span, bpm;
    int     knob_gap, total, ticks, off;
    st = '0;
    case (cmd)
      CMD_STEP: begin
        if (stopwatch < WATCH_MAX) stopwatch++;
        if (hold_cnt > 0) hold_cnt--;
        if (rate != 0) begin
          total     = phase_acc + rate;
          ticks     = total >> PHASE_BITS;
          phase_acc = total & int'(PHASE_ONE - 1);
          if (ticks != 0) begin
            st.advanced = 1'b1;
            for (int i = 0; i < ticks; i++) begin
              playhead = (playhead + 1) % LOOP_TICKS;
              if (playhead % TICKS_PER_BEAT == 0) st.beat_crossed = 1'b1;
              if (playhead == 0) st.loop_wrapped = 1'b1;
            end
          end
        end
      end
      CMD_EDGE: begin
        if (stopwatch > 0 && stopwatch <= gap_limit) begin
          rate = clamp_rate(longint'(TICKS_PER_BEAT) * PHASE_ONE / stopwatch);
          off  = playhead % TICKS_PER_BEAT;
          if (off != 0) begin
            if (off > TICKS_PER_BEAT / 2) playhead = (playhead + 1) % LOOP_TICKS;
            else playhead = (playhead + LOOP_TICKS - 1) % LOOP_TICKS;
          end
        end
        stopwatch = 0;
        hold_cnt  = hold_len;
      end
      CMD_KNOB: begin
        if (hold_cnt > 0) begin
          knob_known = 1'b0;
        end else begin
          knob_gap = knob_last - int'(knob);
          if (knob_gap < 0) knob_gap = -knob_gap;
          if (!knob_known || knob_gap >= move_thr) begin
            knob_last  = int'(knob);
            knob_known = 1'b1;
            span = longint'(bpm_hi) - longint'(bpm_lo);
            bpm  = longint'(bpm_lo) + ((longint'(knob) * span) >>> KNOB_W);
            if (bpm < 0) bpm = 0;
            rate = clamp_rate(bpm * TICKS_PER_BEAT * PHASE_ONE / RATE_DIV);
          end
        end
      end
      default: ;
    endcase
    st.play_position   = playhead[9:0];
    st.clock_following = (hold_cnt > 0);
    st.tick_increment  = rate[INC_W-1:0];
  endtask

  always @(posedge clk) begin
    status_t want, got, st;
    if (!rst_n) begin
      bpm_lo     = 40;
      bpm_hi     = 240;
      move_thr   = 32;
      gap_limit  = 6000;
      hold_len   = 6000;
      phase_acc  = 0;
      rate       = 0;
      playhead   = 0;
      stopwatch  = 0;
      hold_cnt   = 0;
      knob_last  = 0;
      knob_known = 1'b0;
      mis_count  = 0;
      status_due.delete();
      n_in   <= 0;
      n_out  <= 0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BPM_MIN:   bpm_lo    = int'(cfg_data[8:0]);
          REG_BPM_MAX:   bpm_hi    = int'(cfg_data[8:0]);
          REG_KNOB_THR:  move_thr  = int'(cfg_data[KNOB_W-1:0]);
          REG_MAX_GAP:   gap_limit = int'(cfg_data);
          REG_HOLD_STEP: hold_len  = int'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        n_out <= n_out + 1;
        got = {out_advanced, out_play_position, out_beat_crossed, out_loop_wrapped,
               out_clock_following, out_tick_increment};
        if (status_due.size() == 0) begin
          mis_count++;
          if (mis_count <= 10)
            $display("%0t: status item with none pending: %s", $realtime, show(got));
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            mis_count++;
            if (mis_count <= 10)
              $display("%0t: status mismatch, expected %s, got %s",
                       $realtime, show(want), show(got));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_command(in_command, in_knob_position, st);
        status_due.push_back(st);
        n_in <= n_in + 1;
      end
      errors <= mis_count;
    end
  end

endmodule

>>> bench/tb.sv
// Top of the tempo transport bench: clock, reset, stimulus, sink pacing and verdict.
`timescale 1ns / 100ps

module tb;
  import tcft_pkg::*;

  localparam int TICKS_PER_BEAT = 48;
  localparam int LOOP_TICKS     = 768;
  localparam int CONTROL_RATE   = 3000;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int STALL_CYCLES = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int SOAK_STEPS   = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_command;
  logic [KNOB_W-1:0]     in_knob_position;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_advanced;
  logic [9:0]            out_play_position;
  logic                  out_beat_crossed;
  logic                  out_loop_wrapped;
  logic                  out_clock_following;
  logic [INC_W-1:0]      out_tick_increment;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic sink_ready;
  logic sink_block;
  bit   no_gaps;
  bit   long_stall_go;
  int   errors, outstanding;
  int   cycles = 0;
  int   thr_now, gap_now, knob_prev;

  assign out_ready = sink_ready & ~sink_block;

  tempo_clock_follower_transport #(
    .TICKS_PER_BEAT(TICKS_PER_BEAT),
    .LOOP_TICKS    (LOOP_TICKS),
    .CONTROL_RATE  (CONTROL_RATE)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_knob_position   (in_knob_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_advanced       (out_advanced),
    .out_play_position  (out_play_position),
    .out_beat_crossed   (out_beat_crossed),
    .out_loop_wrapped   (out_loop_wrapped),
    .out_clock_following(out_clock_following),
    .out_tick_increment (out_tick_increment),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  tcft_monitor #(
    .TICKS_PER_BEAT(TICKS_PER_BEAT),
    .LOOP_TICKS    (LOOP_TICKS),
    .CONTROL_RATE  (CONTROL_RATE)
  ) i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_knob_position   (in_knob_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_advanced       (out_advanced),
    .out_play_position  (out_play_position),
    .out_beat_crossed   (out_beat_crossed),
    .out_loop_wrapped   (out_loop_wrapped),
    .out_clock_following(out_clock_following),
    .out_tick_increment (out_tick_increment),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .errors             (errors),
    .outstanding        (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tempo_clock_follower_transport test failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [KNOB_W-1:0] kn);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 19);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_knob_position <= kn;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic configure(input int lo, input int hi, input int thr, input int gap,
                           input int hold);
    drain();
    write_reg(REG_BPM_MIN, lo);
    write_reg(REG_BPM_MAX, hi);
    write_reg(REG_KNOB_THR, thr);
    write_reg(REG_MAX_GAP, gap);
    write_reg(REG_HOLD_STEP, hold);
    cfg_valid <= 1'b0;
    thr_now = thr & ((1 << KNOB_W) - 1);
    gap_now = gap & ((1 << CFG_DATA_W) - 1);
  endtask

  // Mostly step runs, some closed by an edge; knob moves, half near the threshold; some noise.
  task automatic run_phase(input int target);
    int sent, pick, k, run_max, kn;
    sent    = 0;
    run_max = (gap_now + 2 > 12) ? 12 : gap_now + 2;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = $urandom_range(1, 8);
        repeat (k) send(CMD_STEP, KNOB_W'($urandom));
        sent += k;
      end else if (pick < 65) begin
        k = $urandom_range(1, run_max);
        repeat (k) send(CMD_STEP, KNOB_W'($urandom));
        send(CMD_EDGE, KNOB_W'($urandom));
        sent += k + 1;
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          kn = $urandom_range(0, 4095);
        end else begin
          k  = thr_now - 1 + $urandom_range(0, 1);
          kn = ($urandom_range(0, 1) == 0) ? knob_prev + k : knob_prev - k;
          if (kn < 0) kn = 0;
          if (kn > 4095) kn = 4095;
        end
        send(CMD_KNOB, KNOB_W'(kn));
        knob_prev = kn;
        sent++;
      end else if (pick < 92) begin
        send(CMD_EDGE, KNOB_W'($urandom));
        send(CMD_EDGE, KNOB_W'($urandom));
        sent += 2;
      end else begin
        send(2'($urandom), KNOB_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sink_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      int w;
      w = no_gaps ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        sink_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      sink_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    sink_block <= 1'b0;
    wait (long_stall_go);
    @(posedge clk);
    sink_block <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    sink_block <= 1'b0;
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_STEP;
    in_knob_position <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_BPM_MIN;
    cfg_data         <= '0;
    no_gaps       = 1'b0;
    long_stall_go = 1'b0;
    thr_now       = 32;
    gap_now       = 6000;
    knob_prev     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: knob path, threshold edge, edges with and without a gap
    send(CMD_KNOB, 12'd0);
    send(CMD_KNOB, 12'd31);
    send(CMD_KNOB, 12'd4095);
    send(CMD_KNOB, 12'd4063);
    repeat (2) send(CMD_STEP, KNOB_W'($urandom));
    send(CMD_SPARE, KNOB_W'($urandom));
    send(CMD_EDGE, KNOB_W'($urandom));
    send(CMD_EDGE, KNOB_W'($urandom));
    send(CMD_KNOB, 12'd1000);
    repeat (3) send(CMD_STEP, KNOB_W'($urandom));
    send(CMD_EDGE, KNOB_W'($urandom));
    repeat (4) send(CMD_STEP, KNOB_W'($urandom));
    send(CMD_EDGE, KNOB_W'($urandom));
    repeat (2) send(CMD_STEP, KNOB_W'($urandom));
    knob_prev = 1000;

    configure(1, 480, 1, 24000, 0);
    run_phase(90);
    configure(480, 1, 4095, 1, 24000);
    long_stall_go = 1'b1;
    run_phase(90);
    configure(0, 511, 0, 32767, 3);
    no_gaps = 1'b1;
    run_phase(90);
    no_gaps = 1'b0;
    configure(240, 40, 32, 6000, 0);
    run_phase(90);
    configure(511, 0, 100, 20, 10);
    run_phase(90);
    repeat (4) begin
      configure($urandom_range(0, 32767), $urandom_range(0, 32767),
                $urandom_range(0, 32767),
                ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 32767),
                ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 32767));
      run_phase(80);
    end

    // stopped transport, a run of steps, then an edge under a gap limit at stopwatch saturation
    configure(0, 0, 0, CONTROL_RATE * EDGE_SAT_MUL, 0);
    no_gaps = 1'b1;
    send(CMD_EDGE, KNOB_W'($urandom));
    send(CMD_KNOB, 12'd0);
    repeat (SOAK_STEPS) send(CMD_STEP, KNOB_W'($urandom));
    send(CMD_EDGE, KNOB_W'($urandom));
    repeat (3) send(CMD_STEP, KNOB_W'($urandom));
    no_gaps = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tempo_clock_follower_transport test passed");
    end else begin
      $display("tempo_clock_follower_transport test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tcft_pkg.sv
hw/rtl/tempo_clock_follower_transport.sv
bench/tcft_monitor.sv
bench/tb.sv
